>>> design/nec_ir_frame_encoder_defines.svh
// Assertion helpers for the infrared frame encoder.
`ifndef NEC_IR_FRAME_ENCODER_DEFINES_SVH
`define NEC_IR_FRAME_ENCODER_DEFINES_SVH

// Clocked check that is switched off while reset is held.
`define NECF_ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Clocked check that also holds while reset is held.
`define NECF_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/necf_pkg.sv
`timescale 1ns / 1ps

package necf_pkg;

	localparam int TICK_W      = 20;
	localparam int UNIT_W      = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [UNIT_W-1:0] UNIT_RESET   = 16'd9000;
	localparam logic              LEGACY_RESET = 1'b0;

	// Register index, taken from paddr[2].
	localparam logic REG_UNIT_TICKS  = 1'b0;
	localparam logic REG_LEGACY_MODE = 1'b1;

	typedef struct packed {
		logic [UNIT_W-1:0] unit_ticks;
		logic              legacy_mode;
	} necf_cfg_t;

	// Keeps the low byte and puts its inverse in the high byte.
	function automatic logic [15:0] fill_inverse(input logic [15:0] v);
		return {~v[7:0], v[7:0]};
	endfunction

endpackage

>>> design/nec_ir_frame_encoder.sv
`timescale 1ns / 1ps
// Channel   Direction  Contents
// s_*       in         frame request: tdata = address [15:0], payload [31:16]
// m_*       out        timing pair: tdata = mark_ticks [19:0], space_ticks [39:20];
//                      tlast marks the stop pair
// APB       in/out     register 0 unit_ticks at 0x0, register 1 legacy_mode at 0x4
//
// Each request yields FRAME_BITS+2 pairs, one per cycle from the pair sequencer
// in the back end; frames queued behind one another follow with no idle cycle.
// A request passes the front stage and the queue before the sequencer registers its first pair.
// Requests are taken while the sequencer runs, until the front stage and the
// two-entry queue are full. A stall on m_tready holds the pair and the sequencer.
// Reset clears the handshake state and sets the registers to their reset values.

module nec_ir_frame_encoder #(
	parameter int FRAME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // address [15:0], payload [31:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // mark_ticks [19:0], space_ticks [39:20]
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import necf_pkg::*;

	necf_cfg_t             cfg_q;
	logic                  cfg_write;
	logic                  push_valid;
	logic                  push_ready;
	logic [FRAME_BITS-1:0] push_word;
	logic                  pop_valid;
	logic                  pop;
	logic [FRAME_BITS-1:0] pop_word;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit_ticks  <= UNIT_RESET;
			cfg_q.legacy_mode <= LEGACY_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_UNIT_TICKS:  cfg_q.unit_ticks  <= pwdata[UNIT_W-1:0];
				REG_LEGACY_MODE: cfg_q.legacy_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_UNIT_TICKS:  prdata = {16'h0000, cfg_q.unit_ticks};
			REG_LEGACY_MODE: prdata = {31'h0, cfg_q.legacy_mode};
			default:         prdata = '0;
		endcase
	end

	necf_front #(.FRAME_BITS(FRAME_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_word (push_word)
	);

	necf_fifo #(.WIDTH(FRAME_BITS)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_word (push_word),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_word  (pop_word)
	);

	necf_back #(.FRAME_BITS(FRAME_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pop_valid(pop_valid),
		.pop      (pop),
		.pop_word (pop_word),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

>>> design/necf_front.sv
`timescale 1ns / 1ps

module necf_front #(
	parameter int FRAME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  necf_pkg::necf_cfg_t   cfg,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [31:0]           s_tdata,
	output logic                  push_valid,
	input  logic                  push_ready,
	output logic [FRAME_BITS-1:0] push_word
);
	import necf_pkg::*;

	logic                  valid_s1;
	logic [FRAME_BITS-1:0] word_s1;
	logic [31:0]           frame_word;
	logic                  accept;

	always_comb begin
		if (cfg.legacy_mode) begin
			frame_word = {fill_inverse(s_tdata[31:16]), fill_inverse(s_tdata[15:0])};
		end else begin
			frame_word = s_tdata;
		end
	end

	assign s_tready   = !valid_s1 || push_ready;
	assign accept     = s_tvalid && s_tready;
	assign push_valid = valid_s1;
	assign push_word  = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= frame_word[FRAME_BITS-1:0];
		end
	end

endmodule

>>> design/necf_fifo.sv
`timescale 1ns / 1ps

module necf_fifo #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_word,
	output logic             pop_valid,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_word
);
	import necf_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != FULL_CNT);
	assign pop_valid  = (count_q != '0);
	assign pop_word   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

endmodule

>>> design/necf_back.sv
`timescale 1ns / 1ps

module necf_back #(
	parameter int FRAME_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  necf_pkg::necf_cfg_t         cfg,
	input  logic                        pop_valid,
	output logic                        pop,
	input  logic [FRAME_BITS-1:0]       pop_word,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [2*necf_pkg::TICK_W-1:0] m_tdata,
	output logic                        m_tlast
);
	import necf_pkg::*;

	localparam int CNT_W = $clog2(FRAME_BITS + 2);
	localparam logic [CNT_W-1:0] STOP_IDX = CNT_W'(FRAME_BITS + 1);

	logic                  busy_q;
	logic [CNT_W-1:0]      pair_q;
	logic [FRAME_BITS-1:0] shift_q;
	logic                  out_valid_q;
	logic [TICK_W-1:0]     mark_q;
	logic [TICK_W-1:0]     space_q;
	logic                  last_q;

	logic                  advance;
	logic                  at_stop;
	logic                  frame_start;
	logic [TICK_W-1:0]     unit_w;
	logic [TICK_W-1:0]     mark_d;
	logic [TICK_W-1:0]     space_d;

	assign advance     = busy_q && (!out_valid_q || m_tready);
	assign at_stop     = (pair_q == STOP_IDX);
	// A queued frame starts right behind the stop pair of the one before it.
	assign frame_start = pop_valid && (!busy_q || (advance && at_stop));
	assign pop         = frame_start;
	assign unit_w      = TICK_W'(cfg.unit_ticks);

	always_comb begin
		if (pair_q == '0) begin
			mark_d  = {cfg.unit_ticks, 4'b0000};
			space_d = TICK_W'({cfg.unit_ticks, 3'b000});
		end else if (at_stop) begin
			mark_d  = unit_w;
			space_d = '0;
		end else if (shift_q[0]) begin
			mark_d  = unit_w;
			space_d = unit_w + TICK_W'({cfg.unit_ticks, 1'b0});
		end else begin
			mark_d  = unit_w;
			space_d = unit_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pair_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (frame_start) begin
				busy_q <= 1'b1;
				pair_q <= '0;
			end else if (advance) begin
				busy_q <= !at_stop;
				pair_q <= pair_q + 1'b1;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_start) begin
			shift_q <= pop_word;
		end else if (advance && pair_q != '0) begin
			shift_q <= shift_q >> 1;
		end
		if (advance) begin
			mark_q  <= mark_d;
			space_q <= space_d;
			last_q  <= at_stop;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {space_q, mark_q};
	assign m_tlast  = last_q;

endmodule

>>> design/necf_checker.sv
`timescale 1ns / 1ps
`include "nec_ir_frame_encoder_defines.svh"

module necf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast
);

	// A stalled pair must be held as it is.
	`NECF_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output pair changed while stalled")

	// The stop pair carries no space.
	`NECF_ASSERT_CLK(a_stop_space, m_tvalid && m_tlast |-> m_tdata[39:20] == 20'd0, "stop pair has a non-zero space")

	// Other pairs are a leader (mark twice the space) or a bit (space one or three marks).
	`NECF_ASSERT_CLK(a_pair_shape, m_tvalid && !m_tlast |-> (m_tdata[39:20] == m_tdata[19:0]) || (m_tdata[39:20] == m_tdata[19:0] + {m_tdata[18:0], 1'b0}) || (m_tdata[19:0] == {m_tdata[38:20], 1'b0}), "pair is neither leader nor bit")

	// Once reset has been seen at an edge, nothing is offered on the output at the next one.
	`NECF_ASSERT_RST(a_reset_quiet, !arst_n |=> !m_tvalid, "output valid during reset")

endmodule

bind nec_ir_frame_encoder necf_checker u_necf_checker (.*);

>>> verif/necf_pair_checker.sv
`timescale 1ns / 1ps

module necf_pair_checker #(
	parameter int FRAME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // address [15:0], payload [31:16]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,   // mark_ticks [19:0], space_ticks [39:20]
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	output int          mismatches,
	output int          outstanding,
	output int          pairs_checked
);
	import necf_pkg::*;

	localparam int LEADER_MARK_UNITS  = 16;
	localparam int LEADER_SPACE_UNITS = 8;
	localparam int ONE_SPACE_UNITS    = 3;

	typedef struct packed {
		logic [TICK_W-1:0] mark;
		logic [TICK_W-1:0] space;
		logic              stop;
	} ir_pair_t;

	necf_cfg_t shadow_cfg = '{UNIT_RESET, LEGACY_RESET};
	ir_pair_t  expected_pairs[$];
	int        error_total = 0;
	int        pair_total  = 0;

	initial begin
		mismatches    = 0;
		outstanding   = 0;
		pairs_checked = 0;
	end

	// Expands one frame request into its leader, data bit and stop pairs.
	function automatic void predict_frame(input logic [15:0] addr, input logic [15:0] payload);
		logic [31:0]       word;
		logic [TICK_W-1:0] unit;
		ir_pair_t          pair;
		if (shadow_cfg.legacy_mode) begin
			addr    = {~addr[7:0], addr[7:0]};
			payload = {~payload[7:0], payload[7:0]};
		end
		word = {payload, addr};
		unit = TICK_W'(shadow_cfg.unit_ticks);
		pair.mark  = TICK_W'(unit * LEADER_MARK_UNITS);
		pair.space = TICK_W'(unit * LEADER_SPACE_UNITS);
		pair.stop  = 1'b0;
		expected_pairs.push_back(pair);
		for (int i = 0; i < FRAME_BITS; i++) begin
			pair.mark  = unit;
			pair.space = word[i] ? TICK_W'(unit * ONE_SPACE_UNITS) : unit;
			pair.stop  = 1'b0;
			expected_pairs.push_back(pair);
		end
		pair.mark  = unit;
		pair.space = '0;
		pair.stop  = 1'b1;
		expected_pairs.push_back(pair);
	endfunction

	always @(posedge clk) begin
		ir_pair_t due;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_UNIT_TICKS) begin
					shadow_cfg.unit_ticks = pwdata[UNIT_W-1:0];
				end else begin
					shadow_cfg.legacy_mode = pwdata[0];
				end
			end
			if (s_tvalid && s_tready) begin
				predict_frame(s_tdata[15:0], s_tdata[31:16]);
			end
			if (m_tvalid && m_tready) begin
				if (expected_pairs.size() == 0) begin
					$display("%0t: pair with no request waiting: expected none, actual mark %0d space %0d last %0b",
						$time, m_tdata[19:0], m_tdata[39:20], m_tlast);
					error_total++;
				end else begin
					due = expected_pairs.pop_front();
					pair_total++;
					if (m_tdata[19:0] !== due.mark) begin
						$display("%0t: mark_ticks expected %0d actual %0d",
							$time, due.mark, m_tdata[19:0]);
						error_total++;
					end
					if (m_tdata[39:20] !== due.space) begin
						$display("%0t: space_ticks expected %0d actual %0d",
							$time, due.space, m_tdata[39:20]);
						error_total++;
					end
					if (m_tlast !== due.stop) begin
						$display("%0t: last expected %0b actual %0b", $time, due.stop, m_tlast);
						error_total++;
					end
				end
			end
		end
		mismatches    <= error_total;
		outstanding   <= expected_pairs.size();
		pairs_checked <= pair_total;
	end

endmodule

>>> verif/tb_nec_ir_frame_encoder.sv
`timescale 1ns / 1ps

module tb_nec_ir_frame_encoder;
	import necf_pkg::*;

	localparam int FRAME_BITS    = 32;
	localparam int RESET_CYCLES  = 9;
	localparam int TOTAL_ITEMS   = 410;
	localparam int CALM_ITEMS    = 40;
	localparam int SETTLE_CYCLES = 12;
	localparam int CYCLE_LIMIT   = 1_000_000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // address [15:0], payload [31:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // mark_ticks [19:0], space_ticks [39:20]
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          mismatches;
	int          outstanding;
	int          pairs_checked;
	int          cycle_count = 0;
	int          requests_sent = 0;
	int          settings_used = 0;
	int          stall_left = 0;
	bit          idle_on = 1'b1;
	logic [15:0] prev_addr = '0;
	logic [15:0] prev_payload = '0;

	nec_ir_frame_encoder #(.FRAME_BITS(FRAME_BITS)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	necf_pair_checker #(.FRAME_BITS(FRAME_BITS)) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.pairs_checked (pairs_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d pairs outstanding.",
				cycle_count, outstanding);
			$display("Verification failed");
			$finish;
		end
	end

	// The receiver holds off in bursts of random length while idling is on.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready   <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 12);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Unused upper bits of each register write carry noise, which must be dropped.
	task automatic set_registers(input logic [15:0] unit, input logic legacy);
		logic [15:0] noise_hi;
		logic [30:0] noise_lo;
		noise_hi = 16'($urandom);
		noise_lo = 31'($urandom);
		wait_drained();
		apb_write({REG_UNIT_TICKS, 2'b00}, {noise_hi, unit});
		apb_write({REG_LEGACY_MODE, 2'b00}, {noise_lo, legacy});
		settings_used++;
	endtask

	task automatic send_request(input logic [15:0] addr, input logic [15:0] payload);
		if (idle_on && $urandom_range(0, 2) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {payload, addr};
		do @(posedge clk); while (!s_tready);
		prev_addr    = addr;
		prev_payload = payload;
		requests_sent++;
	endtask

	// One request in ten repeats the previous one exactly.
	task automatic send_random_request();
		logic [15:0] addr;
		logic [15:0] payload;
		addr    = 16'($urandom);
		payload = 16'($urandom);
		if ($urandom_range(0, 9) == 0) begin
			addr    = prev_addr;
			payload = prev_payload;
		end
		send_request(addr, payload);
	endtask

	initial begin
		logic [15:0] unit;
		int          burst;
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers still at their reset values.
		send_request(16'h0000, 16'h0000);
		send_request(16'hFFFF, 16'hFFFF);
		send_request(16'hAAAA, 16'h5555);
		send_request(16'h5555, 16'hAAAA);
		send_request(16'h0001, 16'h8000);
		send_request(16'h8000, 16'h0001);
		send_request(16'h1234, 16'hABCD);
		send_request(16'h1234, 16'hABCD);

		// Shortest non-zero unit in legacy mode: the high bytes must be ignored.
		set_registers(16'd1, 1'b1);
		send_request(16'h00FF, 16'hFF00);
		send_request(16'hC312, 16'h3480);
		send_request(16'hFFFF, 16'hFFFF);
		send_request(16'h0000, 16'h0000);

		// A unit of zero gives pairs of zero length.
		set_registers(16'd0, 1'b0);
		send_request(16'hFFFF, 16'h0000);
		send_request(16'hA5A5, 16'h5A5A);

		// Largest unit fills the tick fields to their top.
		set_registers(16'hFFFF, 1'b0);
		send_request(16'hFFFF, 16'hFFFF);
		send_request(16'h0000, 16'h0000);
		set_registers(16'hFFFF, 1'b1);
		send_request(16'h7F80, 16'h807F);

		while (requests_sent < TOTAL_ITEMS - CALM_ITEMS) begin
			case ($urandom_range(0, 5))
				0:       unit = 16'd0;
				1:       unit = 16'd1;
				2:       unit = 16'hFFFF;
				default: unit = 16'($urandom);
			endcase
			set_registers(unit, 1'($urandom_range(0, 1)));
			idle_on = ($urandom_range(0, 3) != 0);
			burst   = $urandom_range(15, 50);
			repeat (burst) send_random_request();
		end

		// Closing stretch runs flat out on both sides.
		unit = 16'($urandom);
		set_registers(unit, 1'($urandom_range(0, 1)));
		idle_on = 1'b0;
		repeat (CALM_ITEMS) send_random_request();
		wait_drained();

		$display("Sent %0d frame requests under %0d register settings; %0d pairs compared.",
			requests_sent, settings_used, pairs_checked);
		$display("Units of zero, one and the maximum were used in full and legacy byte modes.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
